FILE: design/pnmht_pkg.sv
// Shared types and constants for the PNM header tokenizer.
// No dependencies; imported by pnmht_step, pnm_header_tokenizer_unit and tb.
`timescale 1ns / 1ps

package pnmht_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int TOKEN_W         = 32;

  // Token kinds requested on req_type
  localparam logic [1:0] KIND_INT = 2'd0;
  localparam logic [1:0] KIND_BIT = 2'd1;

  // ASCII codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_EOF      = 2'd2,
    ST_SAT      = 2'd3
  } pnmht_status_t;

  // Scanner control flags carried between beats
  typedef struct packed {
    logic in_number;
    logic in_comment;
    logic overflowed;
  } pnmht_flags_t;

  // Result produced by one step
  typedef struct packed {
    logic                emit;
    logic [TOKEN_W-1:0]  value;
    pnmht_status_t       status;
  } pnmht_result_t;

endpackage

FILE: design/pnmht_step.sv
// Next-state and result logic for one byte of the tokenizer.
// Depends on pnmht_pkg.
`timescale 1ns / 1ps

module pnmht_step #(
  parameter int VALUE_WIDTH = pnmht_pkg::VALUE_WIDTH_DEF
) (
  input  logic [7:0]                 data_byte,
  input  logic                       end_of_input,
  input  logic [1:0]                 req_type,
  input  pnmht_pkg::pnmht_flags_t    flags,
  input  logic [VALUE_WIDTH-1:0]     acc,
  output pnmht_pkg::pnmht_flags_t    flags_nxt,
  output logic [VALUE_WIDTH-1:0]     acc_nxt,
  output pnmht_pkg::pnmht_result_t   result
);
  import pnmht_pkg::*;

  localparam int PROD_W = VALUE_WIDTH + 4;

  logic                      is_digit;
  logic                      is_space;
  logic                      is_eol;
  logic [3:0]                digit;
  logic [PROD_W-1:0]         prod;
  logic                      prod_ovf;
  logic [VALUE_WIDTH-1:0]    acc_add;
  logic [VALUE_WIDTH-1:0]    acc_first;
  logic                      ovf_first;
  logic [TOKEN_W+VALUE_WIDTH-1:0] acc_ext;
  logic [TOKEN_W-1:0]        num_value;
  pnmht_status_t             num_status;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_eol   = (data_byte == CH_LF) || (data_byte == CH_CR);
  assign is_space = is_eol || (data_byte == CH_SPACE) || (data_byte == CH_TAB);
  assign digit    = 4'(data_byte - CH_ZERO);

  // acc*10 + d; saturate when any bit lands above the value width
  assign prod     = {3'b000, acc, 1'b0} + {1'b0, acc, 3'b000} + PROD_W'(digit);
  assign prod_ovf = |prod[PROD_W-1:VALUE_WIDTH];
  assign acc_add  = prod_ovf ? {VALUE_WIDTH{1'b1}} : prod[VALUE_WIDTH-1:0];

  // first digit of a fresh integer starts from zero
  assign acc_first = VALUE_WIDTH'(digit);
  assign ovf_first = 1'b0;

  assign acc_ext    = {{TOKEN_W{1'b0}}, acc};
  assign num_value  = acc_ext[TOKEN_W-1:0];
  assign num_status = flags.overflowed ? ST_SAT : ST_OK;

  always_comb begin
    flags_nxt     = flags;
    acc_nxt       = acc;
    result.emit   = 1'b0;
    result.value  = '0;
    result.status = ST_OK;
    if (end_of_input) begin
      flags_nxt     = '0;
      acc_nxt       = '0;
      result.emit   = 1'b1;
      result.status = ST_EOF;
    end else if (flags.in_comment) begin
      if (is_eol) begin
        flags_nxt.in_comment = 1'b0;
        if (flags.in_number) begin
          flags_nxt     = '0;
          acc_nxt       = '0;
          result.emit   = 1'b1;
          result.value  = num_value;
          result.status = num_status;
        end
      end
    end else if (flags.in_number) begin
      if (data_byte == CH_HASH) begin
        flags_nxt.in_comment = 1'b1;
      end else if (is_digit) begin
        acc_nxt              = acc_add;
        flags_nxt.overflowed = flags.overflowed | prod_ovf;
      end else begin
        flags_nxt     = '0;
        acc_nxt       = '0;
        result.emit   = 1'b1;
        result.value  = num_value;
        result.status = num_status;
      end
    end else if (req_type != KIND_INT && req_type != KIND_BIT) begin
      flags_nxt    = '0;
      acc_nxt      = '0;
      result.emit  = 1'b1;
      result.value = TOKEN_W'(data_byte);
    end else if (data_byte == CH_HASH) begin
      flags_nxt.in_comment = 1'b1;
    end else if (is_space) begin
      flags_nxt = flags;
    end else if (req_type == KIND_BIT) begin
      flags_nxt   = '0;
      acc_nxt     = '0;
      result.emit = 1'b1;
      if (data_byte == CH_ZERO || data_byte == CH_ONE) begin
        result.value = TOKEN_W'(data_byte == CH_ONE);
      end else begin
        result.status = ST_BAD_CHAR;
      end
    end else if (!is_digit) begin
      flags_nxt     = '0;
      acc_nxt       = '0;
      result.emit   = 1'b1;
      result.status = ST_BAD_CHAR;
    end else begin
      flags_nxt.in_number  = 1'b1;
      flags_nxt.overflowed = ovf_first;
      acc_nxt              = acc_first;
    end
  end

endmodule

FILE: design/pnm_header_tokenizer_unit.sv
// PNM header tokenizer, top level: input register, scanner state, result register.
// Each accepted beat is registered, scanned, and its result registered onto out_.
// Throughput: one beat per cycle (single-pass step) unless out_stall backs up.
// Reset: synchronous active-low rst_n clears both valid flags and scanner state.
// Depends on pnmht_pkg and pnmht_step.
`timescale 1ns / 1ps

module pnm_header_tokenizer_unit #(
  parameter int VALUE_WIDTH = pnmht_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  input  logic [1:0]  in_req_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_token_value,
  output logic [1:0]  out_status
);
  import pnmht_pkg::*;

  // input register
  logic                   in_valid_r;
  logic [7:0]             in_data_byte_r;
  logic                   in_end_r;
  logic [1:0]             in_req_type_r;

  // scanner state
  pnmht_flags_t           flags_r;
  pnmht_flags_t           flags_nxt;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [VALUE_WIDTH-1:0] acc_nxt;

  // result register
  logic                   out_valid_r;
  logic [TOKEN_W-1:0]     out_value_r;
  pnmht_status_t          out_status_r;

  pnmht_result_t          step_res;
  logic                   in_take;
  logic                   advance;

  pnmht_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .data_byte    (in_data_byte_r),
    .end_of_input (in_end_r),
    .req_type     (in_req_type_r),
    .flags        (flags_r),
    .acc          (acc_r),
    .flags_nxt    (flags_nxt),
    .acc_nxt      (acc_nxt),
    .result       (step_res)
  );

  // Advance the held beat when it makes no result, or when the result
  // register is empty or being drained this cycle.
  assign advance  = in_valid_r && (!step_res.emit || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_byte_r <= in_data_byte;
      in_end_r       <= in_end_of_input;
      in_req_type_r  <= in_req_type;
    end
  end

  // Scanner state moves only when the held beat is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      acc_r   <= '0;
    end else if (advance) begin
      flags_r <= flags_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.emit) begin
      out_value_r  <= step_res.value;
      out_status_r <= step_res.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_value = out_value_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  // saturation can only be flagged while an integer is being collected
  a_ovf_in_number: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.overflowed |-> flags_r.in_number)
    else $error("overflow flag set outside an integer");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_BAD_CHAR || out_status_r == ST_EOF))
      |-> (out_value_r == '0))
    else $error("error result with nonzero value");

  // end of input leaves the scanner idle
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_end_r) |=> (!flags_r.in_number && !flags_r.in_comment))
    else $error("scanner state not cleared after end of input");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for pnm_header_tokenizer_unit: directed rows, then shaped random
// PNM header/body text checked against an in-bench tokenizer model with random back-pressure.
// Depends on pnmht_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module tb;
  import pnmht_pkg::*;

  localparam int VALUE_WIDTH = 32;
  localparam longint unsigned SAT_LIMIT = (64'd1 << VALUE_WIDTH) - 64'd1;

  // req_type codes the package leaves unnamed
  localparam logic [1:0] KIND_RAW   = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int RANDOM_BEATS = 1800;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [31:0]   value;
    pnmht_status_t status;
  } token_t;

  // One directed beat; typed rows carry the expected token written out by hand
  typedef struct {
    logic [7:0]    data;
    logic          eoi;
    logic [1:0]    req;
    bit            typed;
    logic [31:0]   value;
    pnmht_status_t status;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_end_of_input;
  logic [1:0]  in_req_type;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_token_value;
  logic [1:0]  out_status;

  // Tokenizer model state
  bit              scan_in_number;
  bit              scan_in_comment;
  logic [1:0]      scan_kind;
  longint unsigned scan_acc;
  bit              scan_sat;

  token_t pending_tokens[$];
  int     beats_offered;
  int     failure_count;
  int     cycle_count;
  bit     steady_in;
  bit     steady_out;
  bit     hold_results;

  pnm_header_tokenizer_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_input(in_end_of_input),
    .in_req_type    (in_req_type),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_value(out_token_value),
    .out_status     (out_status)
  );

  // Directed rows: idle end of input, raw and spare kinds, bit tokens, comments,
  // a comment that closes an integer, a bad start, end of input mid-integer, saturation.
  stim_row_t directed_rows [0:27] = '{
    '{8'hFF,    1'b1, KIND_SPARE, 1'b1, 32'd0,        ST_EOF},
    '{8'hFF,    1'b0, KIND_RAW,   1'b1, 32'hFF,       ST_OK},
    '{8'h00,    1'b0, KIND_SPARE, 1'b1, 32'd0,        ST_OK},
    '{CH_SPACE, 1'b0, KIND_BIT,   1'b0, 32'd0,        ST_OK},
    '{CH_ONE,   1'b0, KIND_BIT,   1'b1, 32'd1,        ST_OK},
    '{8'h78,    1'b0, KIND_BIT,   1'b1, 32'd0,        ST_BAD_CHAR},
    '{CH_HASH,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{8'h61,    1'b0, KIND_RAW,   1'b0, 32'd0,        ST_OK},
    '{CH_CR,    1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{8'h34,    1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{8'h32,    1'b0, KIND_RAW,   1'b0, 32'd0,        ST_OK},
    '{CH_HASH,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{8'h7A,    1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_LF,    1'b0, KIND_INT,   1'b1, 32'd42,       ST_OK},
    '{8'h5A,    1'b0, KIND_INT,   1'b1, 32'd0,        ST_BAD_CHAR},
    '{8'h37,    1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_ONE,   1'b1, KIND_BIT,   1'b1, 32'd0,        ST_EOF},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_NINE,  1'b0, KIND_INT,   1'b0, 32'd0,        ST_OK},
    '{CH_TAB,   1'b0, KIND_INT,   1'b1, 32'hFFFF_FFFF, ST_SAT}
  };

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------
  function automatic void reset_scanner();
    scan_in_number  = 1'b0;
    scan_in_comment = 1'b0;
    scan_kind       = KIND_INT;
    scan_acc        = 64'd0;
    scan_sat        = 1'b0;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Multiply-add by ten, pinning at the value-width maximum
  function automatic void accumulate_digit(input logic [7:0] c);
    longint unsigned d;
    d = longint'(c - CH_ZERO);
    if (scan_acc > (SAT_LIMIT - d) / 10) begin
      scan_acc = SAT_LIMIT;
      scan_sat = 1'b1;
    end else begin
      scan_acc = scan_acc * 10 + d;
    end
  endfunction

  function automatic void close_number(output token_t tok);
    tok.value  = scan_acc[31:0];
    tok.status = scan_sat ? ST_SAT : ST_OK;
    reset_scanner();
  endfunction

  // Advance the model by one beat; return 1 when the beat yields a token
  function automatic bit tokenize_byte(input logic [7:0] c, input logic eoi,
                                       input logic [1:0] req, output token_t tok);
    tok.value  = 32'd0;
    tok.status = ST_OK;
    if (eoi) begin
      reset_scanner();
      tok.status = ST_EOF;
      return 1'b1;
    end
    // Inside a comment only a line end matters; it may close a suspended integer
    if (scan_in_comment) begin
      if (c == CH_LF || c == CH_CR) begin
        scan_in_comment = 1'b0;
        if (scan_in_number) begin
          close_number(tok);
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (scan_in_number) begin
      if (c == CH_HASH) begin
        scan_in_comment = 1'b1;
        return 1'b0;
      end
      if (is_digit(c)) begin
        accumulate_digit(c);
        return 1'b0;
      end
      close_number(tok);
      return 1'b1;
    end
    // Idle: sample the requested kind
    scan_kind = req;
    if (scan_kind != KIND_INT && scan_kind != KIND_BIT) begin
      reset_scanner();
      tok.value = {24'd0, c};
      return 1'b1;
    end
    if (c == CH_HASH) begin
      scan_in_comment = 1'b1;
      return 1'b0;
    end
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return 1'b0;
    if (scan_kind == KIND_BIT) begin
      reset_scanner();
      if (c == CH_ZERO || c == CH_ONE) tok.value = (c == CH_ONE) ? 32'd1 : 32'd0;
      else tok.status = ST_BAD_CHAR;
      return 1'b1;
    end
    if (!is_digit(c)) begin
      reset_scanner();
      tok.status = ST_BAD_CHAR;
      return 1'b1;
    end
    scan_in_number = 1'b1;
    scan_acc       = 64'd0;
    scan_sat       = 1'b0;
    accumulate_digit(c);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, hold until accepted
  // ---------------------------------------------------------------------------
  task automatic offer_beat(input logic [7:0] data, input logic eoi, input logic [1:0] req,
                            input bit typed, input token_t typed_tok);
    int     gap;
    token_t predicted;
    gap = steady_in ? 0 : $urandom_range(0, 8);
    // Drop valid only for a real gap so back-to-back beats keep it high
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data_byte    = data;
    in_end_of_input = eoi;
    in_req_type     = req;
    do @(posedge clk); while (in_stall);
    if (tokenize_byte(data, eoi, req, predicted))
      pending_tokens.push_back(typed ? typed_tok : predicted);
    beats_offered++;
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic eoi, input logic [1:0] req);
    offer_beat(data, eoi, req, 1'b0, '{32'd0, ST_OK});
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_line_end();
    return $urandom_range(0, 1) ? CH_LF : CH_CR;
  endfunction

  function automatic logic [7:0] pick_comment_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] pick_nondigit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_digit(c) || c == CH_HASH);
    return c;
  endfunction

  function automatic logic [1:0] pick_text_kind();
    return $urandom_range(0, 1) ? KIND_BIT : KIND_INT;
  endfunction

  // Leading whitespace and, now and then, a full comment line
  task automatic send_leader();
    repeat ($urandom_range(0, 2)) push_byte(pick_space(), 1'b0, pick_text_kind());
    if ($urandom_range(0, 5) == 0) begin
      push_byte(CH_HASH, 1'b0, pick_text_kind());
      repeat ($urandom_range(0, 4))
        push_byte(pick_comment_byte(), 1'b0, 2'($urandom_range(0, 3)));
      push_byte(pick_line_end(), 1'b0, 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic send_integer();
    int digits;
    int ending;
    send_leader();
    // Mostly short numbers; a tenth run to 9 to 12 digits and can saturate
    digits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 5);
    push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0, KIND_INT);
    repeat (digits - 1)
      push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0, 2'($urandom_range(0, 3)));
    ending = $urandom_range(0, 9);
    if (ending == 0) begin
      // broken: end of input in the middle of the digits
      push_byte(8'($urandom_range(0, 255)), 1'b1, 2'($urandom_range(0, 3)));
    end else if (ending == 1) begin
      // comment suspends the number, its line end closes it
      push_byte(CH_HASH, 1'b0, 2'($urandom_range(0, 3)));
      repeat ($urandom_range(0, 3))
        push_byte(pick_comment_byte(), 1'b0, 2'($urandom_range(0, 3)));
      push_byte(pick_line_end(), 1'b0, 2'($urandom_range(0, 3)));
    end else if (ending <= 5) begin
      push_byte(pick_space(), 1'b0, 2'($urandom_range(0, 3)));
    end else begin
      push_byte(pick_nondigit(), 1'b0, 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic send_bit();
    send_leader();
    if ($urandom_range(0, 5) != 0)
      push_byte($urandom_range(0, 1) ? CH_ONE : CH_ZERO, 1'b0, KIND_BIT);
    else
      push_byte(8'($urandom_range(0, 255)), 1'b0, KIND_BIT);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall per beat, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 19) == 0) steady_out = !steady_out;
      if (hold_results) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end
      wait_cycles = steady_out ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string msg);
    failure_count++;
    if (failure_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    token_t expected;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        note_failure($sformatf("unexpected result beat: value %h status %0d",
                               out_token_value, out_status));
      end else begin
        expected = pending_tokens.pop_front();
        if (out_token_value !== expected.value)
          note_failure($sformatf("token_value mismatch: expected %h, got %h",
                                 expected.value, out_token_value));
        if (out_status !== expected.status)
          note_failure($sformatf("status mismatch: expected %0d, got %0d",
                                 expected.status, out_status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  pick;
    bit  hold_started;
    bit  drain_done;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = 8'd0;
    in_end_of_input = 1'b0;
    in_req_type     = KIND_INT;
    steady_in       = 1'b0;
    steady_out      = 1'b0;
    hold_results    = 1'b0;
    hold_started    = 1'b0;
    drain_done      = 1'b0;
    reset_scanner();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      offer_beat(directed_rows[i].data, directed_rows[i].eoi, directed_rows[i].req,
                 directed_rows[i].typed, '{directed_rows[i].value, directed_rows[i].status});

    while (beats_offered < $size(directed_rows) + RANDOM_BEATS) begin
      if ($urandom_range(0, 19) == 0) steady_in = !steady_in;
      // Hold the result side off while beats keep coming, to back up the input
      if (!hold_started && beats_offered > 600) begin
        hold_started = 1'b1;
        hold_results = 1'b1;
        steady_in    = 1'b1;
      end
      // Pause the input once until every pending token has drained
      if (!drain_done && beats_offered > 1200) begin
        drain_done = 1'b1;
        in_valid   = 1'b0;
        while (pending_tokens.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) send_integer();
      else if (pick < 65) send_bit();
      else if (pick < 85)
        push_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1) ? KIND_RAW : KIND_SPARE);
      else if (pick < 92)
        push_byte(8'($urandom_range(0, 255)), 1'b1, 2'($urandom_range(0, 3)));
      else
        push_byte(8'($urandom_range(0, 255)), 1'b0, 2'($urandom_range(0, 3)));
    end
    in_valid = 1'b0;

    // Drain, then wait out DRAIN_CYCLES so the pipeline can show any stray beat
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failure_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
